// ----- hw/rtl/imubc_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU bias calibration package
// Shared types, widths and constants for the six-axis bias calibration and
// motion detection block.
// ----------------------------------------------------------------------------
package imubc_pkg;

  // Number of calibration samples averaged into one set of offsets.
  localparam int CAL_SAMPLES = 500;

  localparam int NUM_AXES  = 6;
  localparam int AXIS_AX   = 0;
  localparam int AXIS_AY   = 1;
  localparam int AXIS_AZ   = 2;
  localparam int AXIS_GX   = 3;
  localparam int AXIS_GY   = 4;
  localparam int AXIS_GZ   = 5;
  localparam int NUM_ACCEL = 3;

  localparam int WORD_W    = 16;
  localparam int ONE_G     = 16384;
  localparam int THR_W     = 14;
  localparam int THR_RESET = 1638;

  // Calibration sum: the magnitude never exceeds CAL_SAMPLES * 2^15.
  localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int MAG_W  = WORD_W - 1 + $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W  = MAG_W + 1;

  // Division by CAL_SAMPLES through a rounded-up reciprocal. With the shift
  // chosen as MAG_W plus the bits of the divisor, the floor is exact.
  localparam int DIV_SHIFT = MAG_W + $clog2(CAL_SAMPLES);
  localparam int MULT_W    = MAG_W + 2;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam int PROD_W    = MAG_W + MULT_W;

  localparam int QMAG_W = WORD_W;
  localparam int OFF_W  = 18;
  localparam int LIM_W  = 30;
  localparam int SQ_W   = 31;
  localparam int SSUM_W = 32;

  typedef logic signed [WORD_W-1:0] axis_word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic        [MULT_W-1:0] mult_t;
  typedef logic        [PROD_W-1:0] prod_t;
  typedef logic        [QMAG_W-1:0] qmag_t;
  typedef logic signed [OFF_W-1:0]  off_t;
  typedef logic        [CNT_W-1:0]  cnt_t;
  typedef logic        [THR_W-1:0]  thr_t;
  typedef logic        [THR_W:0]    lim_base_t;
  typedef logic        [LIM_W-1:0]  lim_t;
  typedef logic        [SQ_W-1:0]   sq_t;
  typedef logic        [SSUM_W-1:0] ssum_t;

  localparam mult_t     DIV_MULT_C = mult_t'(DIV_MULT);
  localparam off_t      ONE_G_OFF  = off_t'(ONE_G);
  localparam lim_base_t ONE_G_LIM  = lim_base_t'(ONE_G);
  localparam lim_t      LO_SQ_RESET = lim_t'((ONE_G - THR_RESET) * (ONE_G - THR_RESET));
  localparam lim_t      HI_SQ_RESET = lim_t'((ONE_G + THR_RESET) * (ONE_G + THR_RESET));

  localparam logic CMD_MEASURE   = 1'b0;
  localparam logic CMD_CALIBRATE = 1'b1;

  typedef struct packed {
    logic       command;
    axis_word_t accel_x;
    axis_word_t accel_y;
    axis_word_t accel_z;
    axis_word_t gyro_x;
    axis_word_t gyro_y;
    axis_word_t gyro_z;
  } sample_t;

  typedef struct packed {
    axis_word_t accel_x_out;
    axis_word_t accel_y_out;
    axis_word_t accel_z_out;
    axis_word_t gyro_x_out;
    axis_word_t gyro_y_out;
    axis_word_t gyro_z_out;
    ssum_t      accel_square_sum;
    logic       moving;
    logic       is_calibrated;
  } result_t;

  // Per-lane control from the sequencing logic in the top level.
  typedef struct packed {
    logic cal_acc;
    logic cal_last;
    logic meas_load;
    logic fin_mul;
    logic fin_write;
  } lane_ctrl_t;

endpackage

// ----- hw/rtl/imubc_sample_if.sv -----
// ----------------------------------------------------------------------------
// IMU sample channel
// Valid/ready channel carrying one six-axis sample and its command bit.
// ----------------------------------------------------------------------------
interface imubc_sample_if;
  logic                valid;
  logic                ready;
  imubc_pkg::sample_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/imubc_result_if.sv -----
// ----------------------------------------------------------------------------
// IMU result channel
// Valid/ready channel carrying one corrected sample and the motion verdict.
// ----------------------------------------------------------------------------
interface imubc_result_if;
  logic                valid;
  logic                ready;
  imubc_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/imu_bias_calibration_motion_detect.sv -----
// A measurement result passes the lane, square and output registers in turn.
// Throughput: one sample per cycle through six axis lanes and the merge stage
// while results are taken. The sample that completes a calibration run holds
// off input while the lanes divide their sums by a reciprocal multiply.
// Reset (asynchronous, active low) clears sums, count, offsets and the
// calibrated flag, and sets the motion threshold to 1638; no clearing pass.
// ----------------------------------------------------------------------------
// IMU bias calibration and motion detection
// Averages calibration samples into per-axis offsets, corrects measurement
// samples and flags motion when the accel magnitude leaves the one-g window.
// ----------------------------------------------------------------------------
module imu_bias_calibration_motion_detect (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  imubc_pkg::thr_t  cfg_wdata_i,
  imubc_sample_if.sink     sample_i,
  imubc_result_if.source   result_o
);

  logic                  accept, cal_acc, cal_last, meas_load;
  imubc_pkg::cnt_t       cnt_q, cnt_d;
  logic [1:0]            fin_q;
  logic                  cal_flag_q;
  logic                  s1_valid_q, s1_cal_q, s1_free, s1_take;
  imubc_pkg::lane_ctrl_t lane_ctrl;
  imubc_pkg::axis_word_t raw  [imubc_pkg::NUM_AXES];
  imubc_pkg::axis_word_t corr [imubc_pkg::NUM_AXES];

  assign s1_free        = !s1_valid_q || s1_take;
  assign sample_i.ready = s1_free && !(|fin_q);

  assign accept    = sample_i.valid && sample_i.ready;
  assign cal_acc   = accept && (sample_i.data.command == imubc_pkg::CMD_CALIBRATE);
  assign meas_load = accept && (sample_i.data.command == imubc_pkg::CMD_MEASURE);
  assign cal_last  = cal_acc && (cnt_q == imubc_pkg::cnt_t'(imubc_pkg::CAL_SAMPLES - 1));

  assign cnt_d = cal_last ? '0 : (cal_acc ? cnt_q + imubc_pkg::cnt_t'(1) : cnt_q);

  always_comb begin
    lane_ctrl.cal_acc   = cal_acc;
    lane_ctrl.cal_last  = cal_last;
    lane_ctrl.meas_load = meas_load;
    lane_ctrl.fin_mul   = fin_q[0];
    lane_ctrl.fin_write = fin_q[1];
    raw[imubc_pkg::AXIS_AX] = sample_i.data.accel_x;
    raw[imubc_pkg::AXIS_AY] = sample_i.data.accel_y;
    raw[imubc_pkg::AXIS_AZ] = sample_i.data.accel_z;
    raw[imubc_pkg::AXIS_GX] = sample_i.data.gyro_x;
    raw[imubc_pkg::AXIS_GY] = sample_i.data.gyro_y;
    raw[imubc_pkg::AXIS_GZ] = sample_i.data.gyro_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      fin_q      <= '0;
      cal_flag_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      fin_q <= {fin_q[0], cal_last};
      if (fin_q[1]) begin
        cal_flag_q <= 1'b1;
      end
      if (s1_free) begin
        s1_valid_q <= meas_load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (meas_load) begin
      s1_cal_q <= cal_flag_q;
    end
  end

  for (genvar g = 0; g < imubc_pkg::NUM_AXES; g++) begin : g_lane
    imubc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lane_ctrl),
      .z_adjust_i (g == imubc_pkg::AXIS_AZ),
      .raw_i      (raw[g]),
      .corr_o     (corr[g])
    );
  end

  imubc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s1_valid_i  (s1_valid_q),
    .s1_cal_i    (s1_cal_q),
    .corr_i      (corr),
    .s1_take_o   (s1_take),
    .result_o    (result_o)
  );

`ifndef SYNTHESIS
  // No sample may enter while the offsets of a finished run are being formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (|fin_q) |-> !sample_i.ready)
    else $error("sample accepted during offset update");

  assert property (@(posedge clk_i) disable iff (!rst_ni) fin_q[0] |=> fin_q[1])
    else $error("offset update sequence broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cal_flag_q |=> cal_flag_q)
    else $error("calibrated flag cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= imubc_pkg::cnt_t'(imubc_pkg::CAL_SAMPLES - 1))
    else $error("calibration count out of range");
`endif

endmodule

// ----- hw/rtl/imubc_lane.sv -----
// ----------------------------------------------------------------------------
// IMU axis lane
// Accumulates calibration samples for one axis, divides the finished sum by
// the sample count and applies the resulting offset to measurement samples.
// ----------------------------------------------------------------------------
module imubc_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  imubc_pkg::lane_ctrl_t  ctrl_i,
  input  logic                   z_adjust_i,
  input  imubc_pkg::axis_word_t  raw_i,
  output imubc_pkg::axis_word_t  corr_o
);

  imubc_pkg::sum_t       sum_q, sum_d, sum_next;
  imubc_pkg::mag_t       mag_q, mag_d;
  logic                  neg_q, neg_d;
  imubc_pkg::prod_t      prod_q;
  imubc_pkg::qmag_t      qmag;
  imubc_pkg::off_t       quot, offset_q, offset_d;
  imubc_pkg::axis_word_t corr_q;

  always_comb begin
    sum_next = sum_q + imubc_pkg::sum_t'(raw_i);
    sum_d    = sum_q;
    if (ctrl_i.cal_acc) begin
      sum_d = ctrl_i.cal_last ? '0 : sum_next;
    end
    neg_d = sum_next[imubc_pkg::SUM_W-1];
    mag_d = imubc_pkg::mag_t'(neg_d ? -sum_next : sum_next);
  end

  // The quotient is formed on the magnitude so that it truncates toward zero.
  always_comb begin
    qmag     = imubc_pkg::qmag_t'(prod_q >> imubc_pkg::DIV_SHIFT);
    quot     = neg_q ? -imubc_pkg::off_t'(qmag) : imubc_pkg::off_t'(qmag);
    offset_d = quot;
    if (z_adjust_i) begin
      offset_d = (quot > imubc_pkg::off_t'(0)) ? quot - imubc_pkg::ONE_G_OFF
                                               : quot + imubc_pkg::ONE_G_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      offset_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (ctrl_i.fin_write) begin
        offset_q <= offset_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cal_last) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
    if (ctrl_i.fin_mul) begin
      prod_q <= imubc_pkg::prod_t'(mag_q) * imubc_pkg::prod_t'(imubc_pkg::DIV_MULT_C);
    end
    if (ctrl_i.meas_load) begin
      corr_q <= raw_i - imubc_pkg::axis_word_t'(offset_q);
    end
  end

  assign corr_o = corr_q;

endmodule

// ----- hw/rtl/imubc_merge.sv -----
// ----------------------------------------------------------------------------
// IMU merge stage
// Squares the corrected accel axes, sums them, tests the sum against the
// one-g window and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module imubc_merge (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  imubc_pkg::thr_t        cfg_wdata_i,
  input  logic                   s1_valid_i,
  input  logic                   s1_cal_i,
  input  imubc_pkg::axis_word_t  corr_i [imubc_pkg::NUM_AXES],
  output logic                   s1_take_o,
  imubc_result_if.source         result_o
);

  imubc_pkg::lim_base_t  lo_base, hi_base;
  imubc_pkg::lim_t       lo_sq_q, hi_sq_q;
  logic                  s2_valid_q, s2_cal_q;
  imubc_pkg::sq_t        sq_d [imubc_pkg::NUM_ACCEL];
  imubc_pkg::sq_t        sq_q [imubc_pkg::NUM_ACCEL];
  imubc_pkg::axis_word_t s2_corr_q [imubc_pkg::NUM_AXES];
  imubc_pkg::ssum_t      sq_sum;
  logic                  out_valid_q;
  imubc_pkg::result_t    out_q, out_d;
  logic                  out_free, s2_en;

  // Window limits are squared once, when the threshold is written.
  assign lo_base = imubc_pkg::ONE_G_LIM - imubc_pkg::lim_base_t'(cfg_wdata_i);
  assign hi_base = imubc_pkg::ONE_G_LIM + imubc_pkg::lim_base_t'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_sq_q <= imubc_pkg::LO_SQ_RESET;
      hi_sq_q <= imubc_pkg::HI_SQ_RESET;
    end else if (cfg_we_i) begin
      lo_sq_q <= imubc_pkg::lim_t'(lo_base) * imubc_pkg::lim_t'(lo_base);
      hi_sq_q <= imubc_pkg::lim_t'(hi_base) * imubc_pkg::lim_t'(hi_base);
    end
  end

  assign out_free  = !out_valid_q || result_o.ready;
  assign s2_en     = !s2_valid_q || out_free;
  assign s1_take_o = s2_en;

  always_comb begin
    for (int i = 0; i < imubc_pkg::NUM_ACCEL; i++) begin
      sq_d[i] = imubc_pkg::sq_t'(32'(corr_i[i]) * 32'(corr_i[i]));
    end
  end

  always_comb begin
    sq_sum = imubc_pkg::ssum_t'(sq_q[0]) + imubc_pkg::ssum_t'(sq_q[1])
           + imubc_pkg::ssum_t'(sq_q[2]);
    out_d.accel_x_out      = s2_corr_q[imubc_pkg::AXIS_AX];
    out_d.accel_y_out      = s2_corr_q[imubc_pkg::AXIS_AY];
    out_d.accel_z_out      = s2_corr_q[imubc_pkg::AXIS_AZ];
    out_d.gyro_x_out       = s2_corr_q[imubc_pkg::AXIS_GX];
    out_d.gyro_y_out       = s2_corr_q[imubc_pkg::AXIS_GY];
    out_d.gyro_z_out       = s2_corr_q[imubc_pkg::AXIS_GZ];
    out_d.accel_square_sum = sq_sum;
    out_d.moving           = (sq_sum < imubc_pkg::ssum_t'(lo_sq_q)) ||
                             (sq_sum > imubc_pkg::ssum_t'(hi_sq_q));
    out_d.is_calibrated    = s2_cal_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_i) begin
      sq_q      <= sq_d;
      s2_corr_q <= corr_i;
      s2_cal_q  <= s1_cal_i;
    end
    if (out_free && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule
